// ===== design/gda_pkg.sv =====
// ----------------------------------------------------------------------------
// gda_pkg
// Shared widths, calendar constants, ALU codes and month tables for the
// Gregorian date shifter.
// ----------------------------------------------------------------------------
package gda_pkg;

    localparam int DEFAULT_OFFSET_BITS = 16;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DNUM_W  = 22;
    localparam int CUM_W   = 9;

    localparam int MAX_YEAR        = 9999;
    localparam int LAST_DAY_NUMBER = 3652058;
    localparam int DAYS_PER_400    = 146097;
    localparam int DAYS_PER_100    = 36524;
    localparam int DAYS_PER_4      = 1461;
    localparam int DAYS_PER_YEAR   = 365;
    localparam int YEARS_PER_400   = 400;
    localparam int YEARS_PER_100   = 100;
    localparam int MONTHS_PER_YEAR = 12;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    function automatic logic [DAY_W-1:0] days_in_month(input logic leap,
                                                       input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] n;
        case (m)
            4'd2:                      n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

    // Days before the first of month m in a common year
    function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [CUM_W-1:0] n;
        case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== design/gda_if.sv =====
// ----------------------------------------------------------------------------
// gda_if
// Valid/ready channels for the date shifter: input date with day offset,
// and shifted date with day number and flags.
// ----------------------------------------------------------------------------
interface gda_in_if
    import gda_pkg::*;
#(
    parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
);
    logic                          valid;
    logic                          ready;
    logic        [YEAR_W-1:0]      start_year;
    logic        [MONTH_W-1:0]     start_month;
    logic        [DAY_W-1:0]       start_day;
    logic signed [OFFSET_BITS-1:0] day_offset;

    modport source (
        output valid, start_year, start_month, start_day, day_offset,
        input  ready
    );
    modport sink (
        input  valid, start_year, start_month, start_day, day_offset,
        output ready
    );
endinterface

interface gda_out_if
    import gda_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [YEAR_W-1:0]    result_year;
    logic [MONTH_W-1:0]   result_month;
    logic [DAY_W-1:0]     result_day;
    logic [DNUM_W-1:0]    day_number;
    logic                 leap_year;
    logic                 out_of_range;

    modport source (
        output valid, result_year, result_month, result_day, day_number,
               leap_year, out_of_range,
        input  ready
    );
    modport sink (
        input  valid, result_year, result_month, result_day, day_number,
               leap_year, out_of_range,
        output ready
    );
endinterface

// ===== design/gda_alu.sv =====
// ----------------------------------------------------------------------------
// gda_alu
// Shared add/subtract unit with sign flag; used for repeated subtraction,
// accumulation and compares by the sequencer.
// ----------------------------------------------------------------------------
module gda_alu
    import gda_pkg::*;
#(
    parameter int W = 24
) (
    input  alu_op_t              op,
    input  logic signed [W-1:0]  a,
    input  logic signed [W-1:0]  b,
    output logic signed [W-1:0]  sum,
    output logic                 neg
);

    always_comb
    begin
        if (op == ALU_SUB)
        begin
            sum = a - b;
        end
        else
        begin
            sum = a + b;
        end
    end

    assign neg = sum[W-1];

endmodule

// ===== design/gregorian_date_add_days.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// Adds a signed day offset to a Gregorian date through a day number counted
// from 0001-01-01, using one shared add/subtract unit under a sequencer.
// ----------------------------------------------------------------------------
// Timing: an invalid start year goes straight to the output stage, and a result
//   outside the calendar skips the day-number split and month stepping; the time
//   is set by the repeated-subtraction loops (400/100-year split of the start
//   year, 400/100/4/1-year split of the day number, month stepping), and a result
//   also waits while the previous result sits unaccepted in the output register.
// Throughput: one item at a time; in_ch.ready is low until the result posts.
// Reset: rst_n asynchronous, active low; sequencer idle, no result pending.
// ----------------------------------------------------------------------------
module gregorian_date_add_days
    import gda_pkg::*;
#(
    parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    gda_in_if.sink     in_ch,
    gda_out_if.source  out_ch
);

    localparam int ACC_W = ((OFFSET_BITS > DNUM_W) ? OFFSET_BITS : DNUM_W) + 2;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIV400 = 4'd1;
    localparam logic [3:0] S_DIV100 = 4'd2;
    localparam logic [3:0] S_CLAMP  = 4'd3;
    localparam logic [3:0] S_ADD    = 4'd4;
    localparam logic [3:0] S_CHECK  = 4'd5;
    localparam logic [3:0] S_R400   = 4'd6;
    localparam logic [3:0] S_R100   = 4'd7;
    localparam logic [3:0] S_R4     = 4'd8;
    localparam logic [3:0] S_R1     = 4'd9;
    localparam logic [3:0] S_MON    = 4'd10;
    localparam logic [3:0] S_FIN    = 4'd11;

    localparam logic [3:0] T_P256  = 4'd0;
    localparam logic [3:0] T_P64   = 4'd1;
    localparam logic [3:0] T_P32   = 4'd2;
    localparam logic [3:0] T_P8    = 4'd3;
    localparam logic [3:0] T_P4    = 4'd4;
    localparam logic [3:0] T_P1    = 4'd5;
    localparam logic [3:0] T_PDIV4 = 4'd6;
    localparam logic [3:0] T_P100  = 4'd7;
    localparam logic [3:0] T_P400  = 4'd8;
    localparam logic [3:0] T_MONTH = 4'd9;
    localparam logic [3:0] T_DAY   = 4'd10;

    localparam logic [4:0] N4_FULL = 5'd24;

    logic [3:0]                    state_reg, state_next;
    logic                          out_valid_reg, out_valid_next;

    logic signed [ACC_W-1:0]       w_reg, w_next;
    logic [YEAR_W-1:0]             raw_year_reg, raw_year_next;
    logic [MONTH_W-1:0]            raw_month_reg, raw_month_next;
    logic [DAY_W-1:0]              raw_day_reg, raw_day_next;
    logic signed [OFFSET_BITS-1:0] off_reg, off_next;
    logic [YEAR_W-1:0]             p_reg, p_next;
    logic [4:0]                    q400_reg, q400_next;
    logic [1:0]                    q100_reg, q100_next;
    logic [MONTH_W-1:0]            cm_reg, cm_next;
    logic [DAY_W-1:0]              cd_reg, cd_next;
    logic                          leap_in_reg, leap_in_next;
    logic [3:0]                    term_reg, term_next;
    logic [DNUM_W-1:0]             tnum_reg, tnum_next;
    logic [YEAR_W-1:0]             year_reg, year_next;
    logic [1:0]                    n100_reg, n100_next;
    logic [4:0]                    n4_reg, n4_next;
    logic [1:0]                    n1_reg, n1_next;
    logic [MONTH_W-1:0]            rm_reg, rm_next;
    logic                          bad_reg, bad_next;

    logic [YEAR_W-1:0]             o_year_reg, o_year_next;
    logic [MONTH_W-1:0]            o_month_reg, o_month_next;
    logic [DAY_W-1:0]              o_day_reg, o_day_next;
    logic [DNUM_W-1:0]             o_dnum_reg, o_dnum_next;
    logic                          o_leap_reg, o_leap_next;
    logic                          o_oor_reg, o_oor_next;

    alu_op_t                       alu_op;
    logic signed [ACC_W-1:0]       alu_b;
    logic signed [ACC_W-1:0]       alu_sum;
    logic                          alu_neg;
    logic signed [ACC_W-1:0]       term_val;

    logic [6:0]                    r100;
    logic                          leap_c;
    logic [MONTH_W-1:0]            cm_c;
    logic [DAY_W-1:0]              dim_c;
    logic [DAY_W-1:0]              cd_c;
    logic                          leap_out;
    logic [DAY_W-1:0]              dim_out;
    logic                          out_free;

    gda_alu #(
        .W (ACC_W)
    ) u_alu (
        .op  (alu_op),
        .a   (w_reg),
        .b   (alu_b),
        .sum (alu_sum),
        .neg (alu_neg)
    );

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.result_year  = o_year_reg;
    assign out_ch.result_month = o_month_reg;
    assign out_ch.result_day   = o_day_reg;
    assign out_ch.day_number   = o_dnum_reg;
    assign out_ch.leap_year    = o_leap_reg;
    assign out_ch.out_of_range = o_oor_reg;

    assign out_free = !out_valid_reg || out_ch.ready;

    // Leap test of the start year from p = year - 1 split by 400 and 100
    assign r100   = w_reg[6:0];
    assign leap_c = ((r100[1:0] == 2'd3) && (r100 != 7'd99)) ||
                    ((q100_reg == 2'd3) && (r100 == 7'd99));

    always_comb
    begin
        if (raw_month_reg == '0)
        begin
            cm_c = 4'd1;
        end
        else if (raw_month_reg > MONTH_W'(MONTHS_PER_YEAR))
        begin
            cm_c = MONTH_W'(MONTHS_PER_YEAR);
        end
        else
        begin
            cm_c = raw_month_reg;
        end
        dim_c = days_in_month(leap_c, cm_c);
        if (raw_day_reg == '0)
        begin
            cd_c = 5'd1;
        end
        else if (raw_day_reg > dim_c)
        begin
            cd_c = dim_c;
        end
        else
        begin
            cd_c = raw_day_reg;
        end
    end

    assign leap_out = (n1_reg == 2'd3) && !((n4_reg == N4_FULL) && (n100_reg != 2'd3));
    assign dim_out  = days_in_month(leap_out, rm_reg);

    always_comb
    begin
        case (term_reg)
            T_P256:  term_val = ACC_W'({p_reg, 8'd0});
            T_P64:   term_val = ACC_W'({p_reg, 6'd0});
            T_P32:   term_val = ACC_W'({p_reg, 5'd0});
            T_P8:    term_val = ACC_W'({p_reg, 3'd0});
            T_P4:    term_val = ACC_W'({p_reg, 2'd0});
            T_P1:    term_val = ACC_W'(p_reg);
            T_PDIV4: term_val = ACC_W'(p_reg[YEAR_W-1:2]);
            T_P100:  term_val = ACC_W'({q400_reg, q100_reg});
            T_P400:  term_val = ACC_W'(q400_reg);
            T_MONTH: term_val = ACC_W'(cum_days(cm_reg) +
                                       CUM_W'(leap_in_reg && (cm_reg > 4'd2)));
            T_DAY:   term_val = ACC_W'(cd_reg - 5'd1);
            default: term_val = '0;
        endcase
    end

    always_comb
    begin
        alu_op = ALU_SUB;
        case (state_reg)
            S_DIV400: alu_b = ACC_W'(YEARS_PER_400);
            S_DIV100: alu_b = ACC_W'(YEARS_PER_100);
            S_ADD:
            begin
                alu_op = (term_reg == T_P100) ? ALU_SUB : ALU_ADD;
                alu_b  = term_val;
            end
            S_R400:   alu_b = ACC_W'(DAYS_PER_400);
            S_R100:   alu_b = ACC_W'(DAYS_PER_100);
            S_R4:     alu_b = ACC_W'(DAYS_PER_4);
            S_R1:     alu_b = ACC_W'(DAYS_PER_YEAR);
            S_MON:    alu_b = ACC_W'(dim_out);
            default:  alu_b = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        w_next         = w_reg;
        raw_year_next  = raw_year_reg;
        raw_month_next = raw_month_reg;
        raw_day_next   = raw_day_reg;
        off_next       = off_reg;
        p_next         = p_reg;
        q400_next      = q400_reg;
        q100_next      = q100_reg;
        cm_next        = cm_reg;
        cd_next        = cd_reg;
        leap_in_next   = leap_in_reg;
        term_next      = term_reg;
        tnum_next      = tnum_reg;
        year_next      = year_reg;
        n100_next      = n100_reg;
        n4_next        = n4_reg;
        n1_next        = n1_reg;
        rm_next        = rm_reg;
        bad_next       = bad_reg;
        o_year_next    = o_year_reg;
        o_month_next   = o_month_reg;
        o_day_next     = o_day_reg;
        o_dnum_next    = o_dnum_reg;
        o_leap_next    = o_leap_reg;
        o_oor_next     = o_oor_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    raw_year_next  = in_ch.start_year;
                    raw_month_next = in_ch.start_month;
                    raw_day_next   = in_ch.start_day;
                    off_next       = in_ch.day_offset;
                    p_next         = in_ch.start_year - 14'd1;
                    w_next         = ACC_W'(p_next);
                    q400_next      = '0;
                    q100_next      = '0;
                    if ((in_ch.start_year == '0) ||
                        (in_ch.start_year > YEAR_W'(MAX_YEAR)))
                    begin
                        bad_next   = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        bad_next   = 1'b0;
                        state_next = S_DIV400;
                    end
                end
            end
            S_DIV400:
            begin
                if (!alu_neg)
                begin
                    w_next    = alu_sum;
                    q400_next = q400_reg + 5'd1;
                end
                else
                begin
                    state_next = S_DIV100;
                end
            end
            S_DIV100:
            begin
                if (!alu_neg)
                begin
                    w_next    = alu_sum;
                    q100_next = q100_reg + 2'd1;
                end
                else
                begin
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                cm_next      = cm_c;
                cd_next      = cd_c;
                leap_in_next = leap_c;
                w_next       = ACC_W'(off_reg);
                term_next    = T_P256;
                state_next   = S_ADD;
            end
            S_ADD:
            begin
                w_next    = alu_sum;
                term_next = term_reg + 4'd1;
                if (term_reg == T_DAY)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if ((w_reg < 0) || (w_reg > ACC_W'(LAST_DAY_NUMBER)))
                begin
                    bad_next   = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    tnum_next  = w_reg[DNUM_W-1:0];
                    year_next  = 14'd1;
                    n100_next  = '0;
                    n4_next    = '0;
                    n1_next    = '0;
                    rm_next    = 4'd1;
                    state_next = S_R400;
                end
            end
            S_R400:
            begin
                if (!alu_neg)
                begin
                    w_next    = alu_sum;
                    year_next = year_reg + YEAR_W'(YEARS_PER_400);
                end
                else
                begin
                    state_next = S_R100;
                end
            end
            S_R100:
            begin
                if ((n100_reg != 2'd3) && !alu_neg)
                begin
                    w_next    = alu_sum;
                    year_next = year_reg + YEAR_W'(YEARS_PER_100);
                    n100_next = n100_reg + 2'd1;
                end
                else
                begin
                    state_next = S_R4;
                end
            end
            S_R4:
            begin
                if (!alu_neg)
                begin
                    w_next    = alu_sum;
                    year_next = year_reg + 14'd4;
                    n4_next   = n4_reg + 5'd1;
                end
                else
                begin
                    state_next = S_R1;
                end
            end
            S_R1:
            begin
                if ((n1_reg != 2'd3) && !alu_neg)
                begin
                    w_next    = alu_sum;
                    year_next = year_reg + 14'd1;
                    n1_next   = n1_reg + 2'd1;
                end
                else
                begin
                    state_next = S_MON;
                end
            end
            S_MON:
            begin
                if ((rm_reg != MONTH_W'(MONTHS_PER_YEAR)) && !alu_neg)
                begin
                    w_next  = alu_sum;
                    rm_next = rm_reg + 4'd1;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (bad_reg)
                    begin
                        o_year_next  = raw_year_reg;
                        o_month_next = raw_month_reg;
                        o_day_next   = raw_day_reg;
                        o_dnum_next  = '0;
                        o_leap_next  = 1'b0;
                        o_oor_next   = 1'b1;
                    end
                    else
                    begin
                        o_year_next  = year_reg;
                        o_month_next = rm_reg;
                        o_day_next   = w_reg[DAY_W-1:0] + 5'd1;
                        o_dnum_next  = tnum_reg;
                        o_leap_next  = leap_out;
                        o_oor_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg         <= w_next;
        raw_year_reg  <= raw_year_next;
        raw_month_reg <= raw_month_next;
        raw_day_reg   <= raw_day_next;
        off_reg       <= off_next;
        p_reg         <= p_next;
        q400_reg      <= q400_next;
        q100_reg      <= q100_next;
        cm_reg        <= cm_next;
        cd_reg        <= cd_next;
        leap_in_reg   <= leap_in_next;
        term_reg      <= term_next;
        tnum_reg      <= tnum_next;
        year_reg      <= year_next;
        n100_reg      <= n100_next;
        n4_reg        <= n4_next;
        n1_reg        <= n1_next;
        rm_reg        <= rm_next;
        bad_reg       <= bad_next;
        o_year_reg    <= o_year_next;
        o_month_reg   <= o_month_next;
        o_day_reg     <= o_day_next;
        o_dnum_reg    <= o_dnum_next;
        o_leap_reg    <= o_leap_next;
        o_oor_reg     <= o_oor_next;
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> (state_reg != S_IDLE))
        else $error("sequencer stayed idle after accepting an item");

    a_oor_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && o_oor_reg) |-> ((o_dnum_reg == '0) && !o_leap_reg))
        else $error("out-of-range result carries day number or leap flag");

    a_result_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !o_oor_reg) |->
            ((o_month_reg != '0) && (o_month_reg <= MONTH_W'(MONTHS_PER_YEAR)) &&
             (o_day_reg != '0) && (o_year_reg != '0) &&
             (o_year_reg <= YEAR_W'(MAX_YEAR)) &&
             (o_dnum_reg <= DNUM_W'(LAST_DAY_NUMBER))))
        else $error("in-range result holds an impossible date");

    a_fin_drains_output: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FIN) && out_free) |=> (out_valid_reg && (state_reg == S_IDLE)))
        else $error("finished item was not posted to the output register");

endmodule

// ===== dv/tb_gregorian_date_add_days.sv =====
// ----------------------------------------------------------------------------
// tb_gregorian_date_add_days
// Self-checking bench for the date shifter. Start with a directed table of
// calendar edge cases, then run randomized dates and offsets. Compare every
// result field with the table's typed values or an in-bench calendar
// predictor, under sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_gregorian_date_add_days;
    import gda_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OFFSET_BITS   = DEFAULT_OFFSET_BITS;
    localparam int RANDOM_ITEMS  = 540;
    localparam int IDLE_LIMIT    = 3000;
    localparam int DRAIN_CYCLES  = 150;
    localparam int RESET_CYCLES  = 7;
    localparam int DIRECTED_ROWS = 22;

    typedef struct packed {
        logic        [YEAR_W-1:0]      year;
        logic        [MONTH_W-1:0]     month;
        logic        [DAY_W-1:0]       day;
        logic        [OFFSET_BITS-1:0] offset;
    } date_req_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [DNUM_W-1:0]  day_number;
        logic               leap;
        logic               oor;
    } shifted_date_t;

    typedef struct {
        int unsigned year;
        int unsigned month;
        int unsigned day;
        int          offset;
        bit          typed;
        int unsigned ry;
        int unsigned rm;
        int unsigned rd;
        int unsigned dn;
        bit          lp;
        bit          oor;
    } directed_row_t;

    // year, month, day, offset, typed, then expected y, m, d, day number, leap, oor
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{1,     1,  1,  0,      1, 1,     1,  1,  0,       0, 0},
        '{9999,  12, 31, 0,      1, 9999,  12, 31, 3652058, 0, 0},
        '{1,     1,  1,  -1,     1, 1,     1,  1,  0,       0, 1},
        '{9999,  12, 31, 1,      1, 9999,  12, 31, 0,       0, 1},
        '{0,     6,  15, 100,    1, 0,     6,  15, 0,       0, 1},
        '{16383, 15, 31, -32768, 1, 16383, 15, 31, 0,       0, 1},
        '{2000,  2,  28, 1,      0, 0, 0, 0, 0, 0, 0},
        '{1900,  2,  28, 1,      0, 0, 0, 0, 0, 0, 0},
        '{2004,  2,  29, 365,    0, 0, 0, 0, 0, 0, 0},
        '{2024,  0,  0,  0,      0, 0, 0, 0, 0, 0, 0},
        '{2023,  15, 31, 0,      0, 0, 0, 0, 0, 0, 0},
        '{2023,  2,  31, 0,      0, 0, 0, 0, 0, 0, 0},
        '{2023,  4,  31, 1,      0, 0, 0, 0, 0, 0, 0},
        '{2000,  12, 31, 32767,  0, 0, 0, 0, 0, 0, 0},
        '{2000,  1,  1,  -32768, 0, 0, 0, 0, 0, 0, 0},
        '{1600,  3,  1,  -1,     0, 0, 0, 0, 0, 0, 0},
        '{2100,  3,  1,  -1,     0, 0, 0, 0, 0, 0, 0},
        '{1,     1,  1,  32767,  0, 0, 0, 0, 0, 0, 0},
        '{9999,  12, 31, -32768, 0, 0, 0, 0, 0, 0, 0},
        '{9911,  5,  17, 32767,  0, 0, 0, 0, 0, 0, 0},
        '{1,     3,  1,  -60,    0, 0, 0, 0, 0, 0, 0},
        '{400,   12, 31, 1,      0, 0, 0, 0, 0, 0, 0}
    };

    logic clk;
    logic rst_n;

    gda_in_if #(.OFFSET_BITS(OFFSET_BITS)) in_ch ();
    gda_out_if                             out_ch ();

    gregorian_date_add_days #(
        .OFFSET_BITS(OFFSET_BITS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    shifted_date_t shifted_dates_due [$];
    int            mismatch_count;
    int            results_seen;
    int            burst_left;
    logic [15:0]   ready_pattern;
    int            ready_phase;

    function automatic bit leap_year_of(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
        case (m)
            2:          return leap_year_of(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:    return 31;
        endcase
    endfunction

    function automatic longint serial_of(input int unsigned y, input int unsigned m,
                                         input int unsigned d);
        longint      n;
        int unsigned p;
        p = y - 1;
        n = 365 * longint'(p) + p / 4 - p / 100 + p / 400;
        for (int unsigned k = 1; k < m; k++)
            n += month_length(y, k);
        return n + d - 1;
    endfunction

    function automatic shifted_date_t shift_date(input date_req_t rq);
        shifted_date_t res;
        int unsigned   y, m, d, r, n400, n100, n4, n1, ry, rm;
        longint        t;
        res.year       = rq.year;
        res.month      = rq.month;
        res.day        = rq.day;
        res.day_number = '0;
        res.leap       = 1'b0;
        res.oor        = 1'b1;
        y = rq.year;
        if (y == 0 || y > MAX_YEAR)
            return res;
        m = rq.month;
        if (m < 1)
            m = 1;
        if (m > MONTHS_PER_YEAR)
            m = MONTHS_PER_YEAR;
        d = rq.day;
        if (d < 1)
            d = 1;
        if (d > month_length(y, m))
            d = month_length(y, m);
        t = serial_of(y, m, d) + longint'($signed(rq.offset));
        if (t < 0 || t > LAST_DAY_NUMBER)
            return res;
        r    = int'(t);
        n400 = r / DAYS_PER_400;
        r    = r % DAYS_PER_400;
        n100 = r / DAYS_PER_100;
        if (n100 == 4)
            n100 = 3;
        r  = r - n100 * DAYS_PER_100;
        n4 = r / DAYS_PER_4;
        r  = r % DAYS_PER_4;
        n1 = r / DAYS_PER_YEAR;
        if (n1 == 4)
            n1 = 3;
        r  = r - n1 * DAYS_PER_YEAR;
        ry = YEARS_PER_400 * n400 + YEARS_PER_100 * n100 + 4 * n4 + n1 + 1;
        rm = 1;
        while (rm < MONTHS_PER_YEAR && r >= month_length(ry, rm))
        begin
            r = r - month_length(ry, rm);
            rm++;
        end
        res.year       = YEAR_W'(ry);
        res.month      = MONTH_W'(rm);
        res.day        = DAY_W'(r + 1);
        res.day_number = DNUM_W'(t);
        res.leap       = leap_year_of(ry);
        res.oor        = 1'b0;
        return res;
    endfunction

    function automatic date_req_t random_request();
        date_req_t   rq;
        int unsigned kind, y, m;
        kind      = $urandom_range(0, 99);
        y         = $urandom_range(1, MAX_YEAR);
        m         = $urandom_range(1, MONTHS_PER_YEAR);
        rq.year   = YEAR_W'(y);
        rq.month  = MONTH_W'(m);
        rq.day    = DAY_W'($urandom_range(1, month_length(y, m)));
        rq.offset = OFFSET_BITS'($urandom);
        if (kind < 55)
        begin
            // plain valid date, full offset range
        end
        else if (kind < 70)
        begin
            // month and year rollover around the first or last day
            rq.day = ($urandom_range(0, 1) == 0) ? DAY_W'(1) : DAY_W'(month_length(y, m));
            case ($urandom_range(0, 2))
                0:       rq.offset = OFFSET_BITS'(int'($urandom_range(0, 80)) - 40);
                1:       rq.offset = OFFSET_BITS'(365);
                default: rq.offset = OFFSET_BITS'(-366);
            endcase
        end
        else if (kind < 80)
        begin
            // push across the ends of the calendar
            if ($urandom_range(0, 1) == 0)
            begin
                y         = $urandom_range(1, 90);
                rq.offset = OFFSET_BITS'(-int'($urandom_range(0, 32768)));
            end
            else
            begin
                y         = $urandom_range(MAX_YEAR - 89, MAX_YEAR);
                rq.offset = OFFSET_BITS'($urandom_range(0, 32767));
            end
            rq.year = YEAR_W'(y);
            rq.day  = DAY_W'($urandom_range(1, month_length(y, m)));
        end
        else if (kind < 90)
        begin
            // malformed month or day, clamped by the block
            rq.month = MONTH_W'($urandom_range(0, 15));
            rq.day   = DAY_W'($urandom_range(0, 31));
            if ($urandom_range(0, 1) == 0)
                rq.month = ($urandom_range(0, 3) == 0) ? MONTH_W'(0) :
                           MONTH_W'($urandom_range(13, 15));
        end
        else
        begin
            // start year outside the calendar
            rq.year  = ($urandom_range(0, 3) == 0) ? YEAR_W'(0) :
                       YEAR_W'($urandom_range(MAX_YEAR + 1, 16383));
            rq.month = MONTH_W'($urandom_range(0, 15));
            rq.day   = DAY_W'($urandom_range(0, 31));
        end
        return rq;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, what);
        mismatch_count++;
    endtask

    task automatic send_date(input date_req_t rq, input shifted_date_t want);
        in_ch.valid       <= 1'b1;
        in_ch.start_year  <= rq.year;
        in_ch.start_month <= rq.month;
        in_ch.start_day   <= rq.day;
        in_ch.day_offset  <= rq.offset;
        do
            @(posedge clk);
        while (!in_ch.ready);
        shifted_dates_due.push_back(want);
    endtask

    task automatic sender_pause();
        int gap;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver stall pattern, re-picked at random from four choices
    always @(posedge clk)
    begin
        if (ready_phase % 64 == 63)
        begin
            case ($urandom_range(0, 3))
                0:       ready_pattern <= 16'hFFFF;
                1:       ready_pattern <= 16'($urandom);
                2:       ready_pattern <= 16'h00FF;
                default: ready_pattern <= 16'h8001;
            endcase
        end
        out_ch.ready <= ready_pattern[ready_phase % 16];
        ready_phase  <= ready_phase + 1;
    end

    always @(posedge clk)
    begin
        shifted_date_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.year       = out_ch.result_year;
            got.month      = out_ch.result_month;
            got.day        = out_ch.result_day;
            got.day_number = out_ch.day_number;
            got.leap       = out_ch.leap_year;
            got.oor        = out_ch.out_of_range;
            if (shifted_dates_due.size() == 0)
                report_mismatch("result with no item pending");
            else
            begin
                want = shifted_dates_due.pop_front();
                if (got.year !== want.year)
                    report_mismatch($sformatf("result_year got %0d want %0d",
                                              got.year, want.year));
                if (got.month !== want.month)
                    report_mismatch($sformatf("result_month got %0d want %0d",
                                              got.month, want.month));
                if (got.day !== want.day)
                    report_mismatch($sformatf("result_day got %0d want %0d",
                                              got.day, want.day));
                if (got.day_number !== want.day_number)
                    report_mismatch($sformatf("day_number got %0d want %0d",
                                              got.day_number, want.day_number));
                if (got.leap !== want.leap)
                    report_mismatch($sformatf("leap_year got %0b want %0b",
                                              got.leap, want.leap));
                if (got.oor !== want.oor)
                    report_mismatch($sformatf("out_of_range got %0b want %0b",
                                              got.oor, want.oor));
            end
            results_seen++;
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[%0t] timeout: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        date_req_t     rq;
        shifted_date_t want;
        clk               = 1'b0;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.start_year  = '0;
        in_ch.start_month = '0;
        in_ch.start_day   = '0;
        in_ch.day_offset  = '0;
        out_ch.ready      = 1'b0;
        ready_pattern     = 16'hFFFF;
        ready_phase       = 0;
        mismatch_count    = 0;
        results_seen      = 0;
        burst_left        = $urandom_range(1, 12);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            rq.year   = YEAR_W'(directed_rows[i].year);
            rq.month  = MONTH_W'(directed_rows[i].month);
            rq.day    = DAY_W'(directed_rows[i].day);
            rq.offset = OFFSET_BITS'(directed_rows[i].offset);
            if (directed_rows[i].typed)
            begin
                want.year       = YEAR_W'(directed_rows[i].ry);
                want.month      = MONTH_W'(directed_rows[i].rm);
                want.day        = DAY_W'(directed_rows[i].rd);
                want.day_number = DNUM_W'(directed_rows[i].dn);
                want.leap       = directed_rows[i].lp;
                want.oor        = directed_rows[i].oor;
            end
            else
                want = shift_date(rq);
            send_date(rq, want);
            sender_pause();
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            rq = random_request();
            send_date(rq, shift_date(rq));
            sender_pause();
        end
        in_ch.valid <= 1'b0;

        while (shifted_dates_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (shifted_dates_due.size() != 0)
            report_mismatch("expected results never arrived");

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
